>>> src/rft_pkg.sv
// Shared types and constants of the rail fence transposer.
`timescale 1ns / 1ps
package rft_pkg;

  localparam int unsigned RAIL_W = 5;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [RAIL_W-1:0] RAIL_RESET = 5'd2;
  // paddr[2] is the register index; byte lanes below it are ignored
  localparam logic REG_RAIL_COUNT = 1'b0;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic emit_init;
    logic emit_step;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close;
    logic dec;
    logic last;
  } stat_t;

endpackage

>>> src/rft_ctrl.sv
// Sequencer for load, walk and emit phases of the rail fence transposer.
`timescale 1ns / 1ps
module rft_ctrl import rft_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_GAP  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.close) begin
            cmd_o.init = 1'b1;
            state_d    = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          cmd_o.clear = !stat_i.dec;
          state_d     = stat_i.dec ? S_GAP : S_LOAD;
        end
      end
      S_GAP: begin
        // let the final scatter write land before reading it back
        cmd_o.emit_init = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_step = 1'b1;
        if (stat_i.last) begin
          cmd_o.clear = 1'b1;
          state_d     = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_LOAD);

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && stat_i.close) |=> busy_o)
    else $error("closing beat did not start a drain");

  a_gap_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_init |=> cmd_o.emit_step)
    else $error("emit pass did not follow the gap");

endmodule

>>> src/rft_dpath.sv
// Block store, zigzag walk generator, scatter buffer and result registers.
`timescale 1ns / 1ps
module rft_dpath import rft_pkg::*; #(
  parameter int unsigned MAX_BLOCK = 64,
  parameter int unsigned MAX_RAILS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  in_t               in_i,
  input  logic [RAIL_W-1:0] rail_count_i,
  output stat_t             stat_o,
  output logic              result_valid_o,
  output result_t           result_o
);

  localparam int unsigned AW = $clog2(MAX_BLOCK);
  localparam int unsigned CW = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SW = $clog2(MAX_BLOCK + 61);
  localparam int unsigned RailCap = (MAX_RAILS < 31) ? MAX_RAILS : 31;
  localparam logic [RAIL_W-1:0] RAIL_CAP = RAIL_W'(RailCap);
  localparam logic [CW-1:0] BLOCK_FULL = CW'(MAX_BLOCK);

  logic [7:0] store_mem [MAX_BLOCK];
  logic [7:0] order_mem [MAX_BLOCK];

  logic [CW-1:0]     count_q;
  logic              mode_q;
  logic [RAIL_W-1:0] rails_q;
  logic [RAIL_W-1:0] rail_q;
  logic [AW-1:0]     pos_q;
  logic              phase_q;
  logic [AW-1:0]     k_q;

  logic              enc_vld_q, scat_vld_q, emit_vld_q;
  logic              walk_last_q, emit_last_q;
  logic [AW-1:0]     scat_pos_q;
  logic [7:0]        st_rd_q, ord_rd_q;

  logic [RAIL_W-1:0] eff_rails;
  logic [5:0]        step_dn, step_up, step_cyc, step_sel;
  logic [SW-1:0]     cand;
  logic              cand_ok;
  logic [AW-1:0]     st_raddr;
  logic [CW-1:0]     count_inc;

  assign count_inc = count_q + CW'(1);

  always_comb begin
    if (rail_count_i == '0) begin
      eff_rails = RAIL_W'(1);
    end else if (rail_count_i > RAIL_CAP) begin
      eff_rails = RAIL_CAP;
    end else begin
      eff_rails = rail_count_i;
    end
  end

  // next position on the current rail: alternate down and up legs
  always_comb begin
    step_dn  = {rails_q - RAIL_W'(1) - rail_q, 1'b0};
    step_up  = {rail_q, 1'b0};
    step_cyc = {rails_q - RAIL_W'(1), 1'b0};
    if (rails_q <= RAIL_W'(1)) begin
      step_sel = 6'd1;
    end else begin
      step_sel = phase_q ? step_up : step_dn;
      if (step_sel == '0) begin
        step_sel = step_cyc;
      end
    end
    cand    = SW'(pos_q) + SW'(step_sel);
    cand_ok = (cand < SW'(count_q));
  end

  assign st_raddr = mode_q ? k_q : pos_q;

  assign stat_o.close = in_i.last_byte || (count_inc == BLOCK_FULL);
  assign stat_o.dec   = mode_q;
  assign stat_o.last  = ((CW'(k_q) + CW'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mode_q      <= 1'b0;
      rails_q     <= RAIL_RESET;
      rail_q      <= '0;
      pos_q       <= '0;
      phase_q     <= 1'b0;
      k_q         <= '0;
      enc_vld_q   <= 1'b0;
      scat_vld_q  <= 1'b0;
      emit_vld_q  <= 1'b0;
    end else begin
      enc_vld_q  <= cmd_i.step && !mode_q;
      scat_vld_q <= cmd_i.step && mode_q;
      emit_vld_q <= cmd_i.emit_step;
      if (cmd_i.load) begin
        if (count_q == '0) begin
          mode_q <= in_i.operation;
        end
        count_q <= count_inc;
      end
      if (cmd_i.init) begin
        rails_q <= eff_rails;
        rail_q  <= '0;
        pos_q   <= '0;
        phase_q <= 1'b0;
        k_q     <= '0;
      end
      if (cmd_i.step) begin
        k_q <= k_q + AW'(1);
      end
      if (cmd_i.emit_init) begin
        k_q <= '0;
      end
      if (cmd_i.emit_step) begin
        k_q <= k_q + AW'(1);
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        rail_q  <= '0;
        pos_q   <= '0;
        phase_q <= 1'b0;
      end else if (cmd_i.step) begin
        if (cand_ok) begin
          pos_q   <= cand[AW-1:0];
          phase_q <= !phase_q;
        end else begin
          // rail exhausted: jump to the head of the next rail
          rail_q  <= rail_q + RAIL_W'(1);
          pos_q   <= AW'(rail_q + RAIL_W'(1));
          phase_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_mem[count_q[AW-1:0]] <= in_i.data_byte;
    end
    st_rd_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (scat_vld_q) begin
      order_mem[scat_pos_q] <= st_rd_q;
    end
    ord_rd_q <= order_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    scat_pos_q  <= pos_q;
    walk_last_q <= stat_o.last;
    emit_last_q <= stat_o.last;
  end

  assign result_valid_o    = enc_vld_q || emit_vld_q;
  assign result_o.out_byte = emit_vld_q ? ord_rd_q : st_rd_q;
  assign result_o.out_last = emit_vld_q ? emit_last_q : walk_last_q;

  a_walk_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (CW'(pos_q) < count_q))
    else $error("walk position outside the block");

  a_rail_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (rail_q < rails_q))
    else $error("walk rail beyond rail count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (count_q < BLOCK_FULL))
    else $error("beat loaded into a full block");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(enc_vld_q && emit_vld_q))
    else $error("walk and emit results collide");

endmodule

>>> src/rail_fence_transposer.sv
// Top level of the rail fence transposer: register port, sequencer and datapath.
//
//  channel   direction  handshake                payload
//  input     in         start / busy             in_i (operation, data_byte, last_byte)
//  result    out        result_valid_o strobe    result_o (out_byte, out_last)
//  config    in/out     psel/penable/pready      rail_count at byte address 0
//
// Loading accepts one byte per cycle while busy is low. A closed block drains
// in a walk for encrypt (one store read per walk step) and for decrypt in a
// walk that scatters into a second buffer, a gap state, a linear read pass; busy
// is high throughout. Results arrive the cycle after each read step, never held.
// Reset clears the control state and sets rail_count to 2; store contents stay.
`timescale 1ns / 1ps
module rail_fence_transposer import rft_pkg::*; #(
  parameter int unsigned MAX_BLOCK = 64,
  parameter int unsigned MAX_RAILS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  in_t               in_i,
  output logic              result_valid_o,
  output result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [RAIL_W-1:0] rail_count_q;
  logic              cfg_wr;
  cmd_t              cmd;
  stat_t             stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_count_q <= RAIL_RESET;
    end else if (cfg_wr && (paddr[2] == REG_RAIL_COUNT)) begin
      rail_count_q <= pwdata[RAIL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RAIL_COUNT) begin
      prdata = DATA_W'(rail_count_q);
    end
  end

  rft_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  rft_dpath #(
    .MAX_BLOCK(MAX_BLOCK),
    .MAX_RAILS(MAX_RAILS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_i          (in_i),
    .rail_count_i  (rail_count_q),
    .stat_o        (stat),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule
